[design/akpd_pkg.sv]
// Shared types, register indexes, reset values and button codes for the keypad decoder.
package akpd_pkg;

   localparam int LEVEL_WIDTH    = 10;
   localparam int INTERVAL_WIDTH = 16;
   localparam int WINDOW_WIDTH   = 5;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CODE_WIDTH     = 3;
   localparam int RSP_DATA_WIDTH = 8;

   typedef logic [CODE_WIDTH-1:0] code_type;

   localparam code_type CODE_NONE      = 3'd0;
   localparam code_type CODE_CHANNEL   = 3'd1;
   localparam code_type CODE_MODE      = 3'd2;
   localparam code_type CODE_MODE_HOLD = 3'd3;
   localparam code_type CODE_COLOR     = 3'd4;
   localparam code_type CODE_SPEED     = 3'd5;

   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   localparam csr_addr_type REG_POLL_INTERVAL = 3'd0;
   localparam csr_addr_type REG_IDLE_THRESH   = 3'd1;
   localparam csr_addr_type REG_HOLD_TIME     = 3'd2;
   localparam csr_addr_type REG_CHANNEL_LEVEL = 3'd3;
   localparam csr_addr_type REG_COLOR_LEVEL   = 3'd4;
   localparam csr_addr_type REG_SPEED_LEVEL   = 3'd5;
   localparam csr_addr_type REG_MODE_LEVEL    = 3'd6;
   localparam csr_addr_type REG_WINDOW_HALF   = 3'd7;

   localparam logic [INTERVAL_WIDTH-1:0] RST_POLL_INTERVAL = 16'd20;
   localparam logic [LEVEL_WIDTH-1:0]    RST_IDLE_THRESH   = 10'd500;
   localparam logic [INTERVAL_WIDTH-1:0] RST_HOLD_TIME     = 16'd800;
   localparam logic [LEVEL_WIDTH-1:0]    RST_CHANNEL_LEVEL = 10'd243;
   localparam logic [LEVEL_WIDTH-1:0]    RST_COLOR_LEVEL   = 10'd14;
   localparam logic [LEVEL_WIDTH-1:0]    RST_SPEED_LEVEL   = 10'd66;
   localparam logic [LEVEL_WIDTH-1:0]    RST_MODE_LEVEL    = 10'd127;
   localparam logic [WINDOW_WIDTH-1:0]   RST_WINDOW_HALF   = 5'd2;

   typedef struct packed {
      logic [INTERVAL_WIDTH-1:0] poll_interval;
      logic [LEVEL_WIDTH-1:0]    idle_threshold;
      logic [INTERVAL_WIDTH-1:0] hold_time;
      logic [LEVEL_WIDTH-1:0]    channel_key_level;
      logic [LEVEL_WIDTH-1:0]    color_key_level;
      logic [LEVEL_WIDTH-1:0]    speed_key_level;
      logic [LEVEL_WIDTH-1:0]    mode_key_level;
      logic [WINDOW_WIDTH-1:0]   window_half;
   } cfg_type;

endpackage

[design/akpd_csr.sv]
// Configuration register file of the keypad decoder.
module akpd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  akpd_pkg::csr_addr_type               csr_addr,
   input  logic [akpd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output akpd_pkg::cfg_type                    cfg
);
   import akpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_POLL_INTERVAL: cfg_in.poll_interval     = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_IDLE_THRESH:   cfg_in.idle_threshold    = csr_wdata[LEVEL_WIDTH-1:0];
            REG_HOLD_TIME:     cfg_in.hold_time         = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_CHANNEL_LEVEL: cfg_in.channel_key_level = csr_wdata[LEVEL_WIDTH-1:0];
            REG_COLOR_LEVEL:   cfg_in.color_key_level   = csr_wdata[LEVEL_WIDTH-1:0];
            REG_SPEED_LEVEL:   cfg_in.speed_key_level   = csr_wdata[LEVEL_WIDTH-1:0];
            REG_MODE_LEVEL:    cfg_in.mode_key_level    = csr_wdata[LEVEL_WIDTH-1:0];
            REG_WINDOW_HALF:   cfg_in.window_half       = csr_wdata[WINDOW_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_interval     <= RST_POLL_INTERVAL;
         cfg_ff.idle_threshold    <= RST_IDLE_THRESH;
         cfg_ff.hold_time         <= RST_HOLD_TIME;
         cfg_ff.channel_key_level <= RST_CHANNEL_LEVEL;
         cfg_ff.color_key_level   <= RST_COLOR_LEVEL;
         cfg_ff.speed_key_level   <= RST_SPEED_LEVEL;
         cfg_ff.mode_key_level    <= RST_MODE_LEVEL;
         cfg_ff.window_half       <= RST_WINDOW_HALF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/akpd_classify.sv]
// Window match of one sample against the four key levels, first match wins.
module akpd_classify #(
   parameter int SAMPLE_WIDTH = 10
) (
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  akpd_pkg::cfg_type       cfg,
   input  logic                    hold_exceeded,
   output akpd_pkg::code_type      code
);
   import akpd_pkg::*;

   localparam int CW = ((SAMPLE_WIDTH > LEVEL_WIDTH) ? SAMPLE_WIDTH : LEVEL_WIDTH) + 1;

   // The window test level - w < s < level + w is rewritten so nothing goes negative.
   function automatic logic win_match(input logic [CW-1:0] s, input logic [CW-1:0] l,
                                      input logic [CW-1:0] w);
      return ((s + w) > l) && (s < (l + w));
   endfunction

   logic [CW-1:0] s_ext;
   logic [CW-1:0] w_ext;
   logic          hit_channel;
   logic          hit_color;
   logic          hit_speed;
   logic          hit_mode;

   assign s_ext = CW'(sample);
   assign w_ext = CW'(cfg.window_half);

   assign hit_channel = win_match(s_ext, CW'(cfg.channel_key_level), w_ext);
   assign hit_color   = win_match(s_ext, CW'(cfg.color_key_level), w_ext);
   assign hit_speed   = win_match(s_ext, CW'(cfg.speed_key_level), w_ext);
   assign hit_mode    = win_match(s_ext, CW'(cfg.mode_key_level), w_ext);

   always_comb begin
      if (hit_channel) begin
         code = CODE_CHANNEL;
      end else if (hit_color) begin
         code = CODE_COLOR;
      end else if (hit_speed) begin
         code = CODE_SPEED;
      end else if (hit_mode) begin
         code = hold_exceeded ? CODE_MODE_HOLD : CODE_MODE;
      end else begin
         code = CODE_NONE;
      end
   end

endmodule

[design/analog_keypad_press_decoder_core.sv]
// An accepted tick transaction is held in the tick register; its press result is then held in the result register.
// Throughput: one tick transaction per cycle; a held result stalls only ticks that emit.
// The tick register, the poll and press timers and the class register form one pass.
// Reset is synchronous and active high: it clears the timers, the current class and
// the valid flags of both pipeline registers, and loads every configuration register
// with its default.
module analog_keypad_press_decoder_core #(
   parameter int SAMPLE_WIDTH = 10,
   parameter int TIMER_WIDTH  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: adc_sample.
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0: button_code.
   output logic [akpd_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   input  logic                                     csr_we,
   input  akpd_pkg::csr_addr_type                   csr_addr,
   input  logic [akpd_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);
   import akpd_pkg::*;

   localparam int CMP_W = (TIMER_WIDTH > INTERVAL_WIDTH) ? TIMER_WIDTH : INTERVAL_WIDTH;

   cfg_type cfg;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic [TIMER_WIDTH-1:0]  since_poll_ff;
   logic [TIMER_WIDTH-1:0]  since_poll_in;
   logic [TIMER_WIDTH-1:0]  since_press_ff;
   logic [TIMER_WIDTH-1:0]  since_press_in;
   code_type                current_ff;
   code_type                current_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   code_type                rsp_code_ff;

   logic [TIMER_WIDTH-1:0]  poll_inc;
   logic [TIMER_WIDTH-1:0]  press_inc;
   logic                    poll_due;
   logic                    is_idle;
   logic                    hold_exceeded;
   code_type                class_code;
   logic                    emit;
   logic                    advance;
   logic                    req_accept;

   akpd_csr u_akpd_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign poll_inc  = (&since_poll_ff) ? since_poll_ff : since_poll_ff + 1'b1;
   assign press_inc = (&since_press_ff) ? since_press_ff : since_press_ff + 1'b1;

   assign poll_due      = CMP_W'(poll_inc) >= CMP_W'(cfg.poll_interval);
   assign hold_exceeded = CMP_W'(press_inc) > CMP_W'(cfg.hold_time);
   assign is_idle       = ((SAMPLE_WIDTH > LEVEL_WIDTH ? SAMPLE_WIDTH : LEVEL_WIDTH)'(s1_sample_ff))
                          > ((SAMPLE_WIDTH > LEVEL_WIDTH ? SAMPLE_WIDTH : LEVEL_WIDTH)'(cfg.idle_threshold));

   akpd_classify #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_akpd_classify (
      .sample        (s1_sample_ff),
      .cfg           (cfg),
      .hold_exceeded (hold_exceeded),
      .code          (class_code)
   );

   assign emit       = poll_due && !is_idle && (class_code != current_ff);
   assign advance    = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      since_poll_in  = since_poll_ff;
      since_press_in = since_press_ff;
      current_in     = current_ff;
      if (advance) begin
         since_poll_in  = poll_inc;
         since_press_in = press_inc;
         if (poll_due) begin
            since_poll_in = '0;
            if (is_idle) begin
               current_in     = CODE_NONE;
               since_press_in = '0;
            end else begin
               current_in = class_code;
               if (emit && (class_code != CODE_MODE_HOLD)) begin
                  since_press_in = '0;
               end
            end
         end
      end
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         since_poll_ff  <= '0;
         since_press_ff <= '0;
         current_ff     <= CODE_NONE;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         since_poll_ff  <= since_poll_in;
         since_press_ff <= since_press_in;
         current_ff     <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
      if (advance && emit) begin
         rsp_code_ff <= class_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_code_ff);

endmodule

[design/akpd_checker.sv]
// Port-level assertions for the keypad decoder and their binding to the top level.
module akpd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [akpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import akpd_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CODE_WIDTH-1:0] <= CODE_SPEED))
      else $error("Button code out of range.");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_WIDTH-1:CODE_WIDTH] == '0))
      else $error("Result padding bits not zero.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result transaction changed.");

endmodule

bind analog_keypad_press_decoder_core akpd_checker u_akpd_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for the analog keypad press decoder, predicting press transactions per tick.
module tb;
   import akpd_pkg::*;

   localparam int SAMPLE_W = 10;
   localparam int TIMER_W  = 16;
   localparam int REQ_W    = ((SAMPLE_W + 7) / 8) * 8;
   localparam int ADC_MAX  = (1 << SAMPLE_W) - 1;

   typedef logic [SAMPLE_W-1:0] sample_type;

   localparam cfg_type RESET_SETTINGS = '{
      poll_interval:     RST_POLL_INTERVAL,
      idle_threshold:    RST_IDLE_THRESH,
      hold_time:         RST_HOLD_TIME,
      channel_key_level: RST_CHANNEL_LEVEL,
      color_key_level:   RST_COLOR_LEVEL,
      speed_key_level:   RST_SPEED_LEVEL,
      mode_key_level:    RST_MODE_LEVEL,
      window_half:       RST_WINDOW_HALF
   };

   class press_scoreboard;
      cfg_type            cfg;
      logic [TIMER_W-1:0] since_poll;
      logic [TIMER_W-1:0] since_press;
      code_type           held_code;
      code_type           expected_codes[$];
      int unsigned        failures;

      function new();
         cfg = RESET_SETTINGS;
         since_poll = '0;
         since_press = '0;
         held_code = CODE_NONE;
         failures = 0;
      endfunction

      function void set_reg(csr_addr_type addr, logic [CSR_DATA_WIDTH-1:0] value);
         case (addr)
            REG_POLL_INTERVAL: cfg.poll_interval = value;
            REG_IDLE_THRESH:   cfg.idle_threshold = value[LEVEL_WIDTH-1:0];
            REG_HOLD_TIME:     cfg.hold_time = value;
            REG_CHANNEL_LEVEL: cfg.channel_key_level = value[LEVEL_WIDTH-1:0];
            REG_COLOR_LEVEL:   cfg.color_key_level = value[LEVEL_WIDTH-1:0];
            REG_SPEED_LEVEL:   cfg.speed_key_level = value[LEVEL_WIDTH-1:0];
            REG_MODE_LEVEL:    cfg.mode_key_level = value[LEVEL_WIDTH-1:0];
            REG_WINDOW_HALF:   cfg.window_half = value[WINDOW_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // Bounds are signed, so a window reaching below zero still admits sample zero.
      function bit in_window(int sample, int level);
         int w;
         w = int'(cfg.window_half);
         return (sample < level + w) && (sample > level - w);
      endfunction

      function code_type classify(int sample);
         if (in_window(sample, int'(cfg.channel_key_level))) return CODE_CHANNEL;
         if (in_window(sample, int'(cfg.color_key_level))) return CODE_COLOR;
         if (in_window(sample, int'(cfg.speed_key_level))) return CODE_SPEED;
         if (in_window(sample, int'(cfg.mode_key_level))) begin
            return (since_press > cfg.hold_time) ? CODE_MODE_HOLD : CODE_MODE;
         end
         return CODE_NONE;
      endfunction

      function void note_tick(sample_type sample);
         code_type prev;
         if (since_poll != '1) since_poll = since_poll + 1'b1;
         if (since_press != '1) since_press = since_press + 1'b1;
         if (since_poll < cfg.poll_interval) return;
         since_poll = '0;
         if (sample > cfg.idle_threshold) begin
            held_code = CODE_NONE;
            since_press = '0;
            return;
         end
         prev = held_code;
         held_code = classify(int'(sample));
         if (prev == held_code) return;
         if (held_code != CODE_MODE_HOLD) since_press = '0;
         expected_codes.push_back(held_code);
      endfunction

      function void check_press(code_type code);
         code_type want;
         if (expected_codes.size() == 0) begin
            $display("%0t: button_code expected none, actual %0d", $time, code);
            failures++;
            return;
         end
         want = expected_codes.pop_front();
         if (want != code) begin
            $display("%0t: button_code expected %0d, actual %0d", $time, want, code);
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   csr_addr_type              csr_addr = REG_POLL_INTERVAL;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   press_scoreboard sb = new();
   cfg_type         plan = RESET_SETTINGS;
   int unsigned     ticks_sent = 0;
   bit              sender_calm = 1'b0;
   logic            rsp_calm = 1'b0;
   logic            hold_rsp = 1'b0;
   int unsigned     rsp_wait = 0;

   analog_keypad_press_decoder_core #(
      .SAMPLE_WIDTH(SAMPLE_W),
      .TIMER_WIDTH (TIMER_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned random_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (!rsp_calm && $urandom_range(99) < 20) begin
         rsp_wait <= random_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_press(rsp_tdata[CODE_WIDTH-1:0]);
      if (!reset && req_tvalid && req_tready) sb.note_tick(req_tdata[SAMPLE_W-1:0]);
   end

   task automatic put_reg(csr_addr_type addr, logic [CSR_DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(addr, value);
   endtask

   task automatic apply_settings(cfg_type c);
      put_reg(REG_POLL_INTERVAL, c.poll_interval);
      put_reg(REG_IDLE_THRESH, CSR_DATA_WIDTH'(c.idle_threshold));
      put_reg(REG_HOLD_TIME, c.hold_time);
      put_reg(REG_CHANNEL_LEVEL, CSR_DATA_WIDTH'(c.channel_key_level));
      put_reg(REG_COLOR_LEVEL, CSR_DATA_WIDTH'(c.color_key_level));
      put_reg(REG_SPEED_LEVEL, CSR_DATA_WIDTH'(c.speed_key_level));
      put_reg(REG_MODE_LEVEL, CSR_DATA_WIDTH'(c.mode_key_level));
      put_reg(REG_WINDOW_HALF, CSR_DATA_WIDTH'(c.window_half));
      csr_we <= 1'b0;
      plan = c;
   endtask

   task automatic send_tick(int sample);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(sample);
      do begin
         @(posedge clock);
      end while (!req_tready);
      ticks_sent++;
      gap = sender_calm ? 0 : random_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The extra margin covers ticks still in flight that emit nothing.
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sb.expected_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int key_sample(int k);
      int level;
      int w;
      int s;
      case (k)
         0: level = int'(plan.channel_key_level);
         1: level = int'(plan.color_key_level);
         2: level = int'(plan.speed_key_level);
         default: level = int'(plan.mode_key_level);
      endcase
      w = int'(plan.window_half);
      s = level + int'($urandom_range(0, 2 * w)) - w;
      if (s < 0) s = 0;
      if (s > ADC_MAX) s = ADC_MAX;
      return s;
   endfunction

   function automatic int idle_sample();
      if (int'(plan.idle_threshold) >= ADC_MAX) return ADC_MAX;
      return int'($urandom_range(int'(plan.idle_threshold) + 1, ADC_MAX));
   endfunction

   function automatic logic [LEVEL_WIDTH-1:0] pick_level(int thr);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 12) return '1;
      return LEVEL_WIDTH'($urandom_range(0, thr));
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) c.poll_interval = 16'($urandom_range(0, 2));
      else if (roll < 85) c.poll_interval = 16'($urandom_range(3, 12));
      else if (roll < 95) c.poll_interval = RST_POLL_INTERVAL;
      else if (roll < 98) c.poll_interval = 16'($urandom_range(13, 400));
      else c.poll_interval = '1;
      roll = $urandom_range(99);
      if (roll < 10) c.idle_threshold = '1;
      else if (roll < 15) c.idle_threshold = '0;
      else c.idle_threshold = LEVEL_WIDTH'($urandom_range(200, ADC_MAX - 1));
      roll = $urandom_range(99);
      if (roll < 10) c.hold_time = '0;
      else if (roll < 75) c.hold_time = 16'($urandom_range(1, 40));
      else if (roll < 95) c.hold_time = 16'($urandom_range(41, 200));
      else c.hold_time = '1;
      c.channel_key_level = pick_level(int'(c.idle_threshold));
      c.color_key_level = pick_level(int'(c.idle_threshold));
      c.speed_key_level = pick_level(int'(c.idle_threshold));
      c.mode_key_level = pick_level(int'(c.idle_threshold));
      roll = $urandom_range(99);
      if (roll < 10) c.window_half = '0;
      else if (roll < 20) c.window_half = 5'd16;
      else c.window_half = WINDOW_WIDTH'($urandom_range(1, 16));
      return c;
   endfunction

   // Mostly key presses with jitter and a release, mixed with noise and broken presses.
   task automatic random_phase();
      int unsigned start;
      int unsigned budget;
      int unsigned roll;
      int len;
      int k;
      int i;
      start = ticks_sent;
      budget = $urandom_range(40, 90);
      while (ticks_sent - start < budget) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            k = $urandom_range(3);
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
            for (i = 0; i < len; i++) send_tick(key_sample(k));
            len = $urandom_range(0, 6);
            for (i = 0; i < len; i++) send_tick(idle_sample());
         end else if (roll < 85) begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) send_tick(int'($urandom_range(0, ADC_MAX)));
         end else begin
            send_tick(key_sample($urandom_range(3)));
            send_tick(key_sample($urandom_range(3)));
            send_tick(int'($urandom_range(0, ADC_MAX)));
         end
      end
   endtask

   initial begin
      cfg_type c;
      int i;
      int phases;
      int probe[15];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: the twentieth tick is the first poll.
      for (i = 0; i < 20; i++) send_tick(int'(RST_CHANNEL_LEVEL));
      settle();

      c = RESET_SETTINGS;
      c.poll_interval = '0;
      c.idle_threshold = 10'd1000;
      c.hold_time = 16'd3;
      c.color_key_level = 10'd1;
      c.speed_key_level = 10'd999;
      apply_settings(c);
      probe = '{0, ADC_MAX, 999, 998, 243, 126, 127, 127, 127, 127, 300, 1001, 300, 245, 242};
      for (i = 0; i < 15; i++) send_tick(probe[i]);
      settle();

      c.window_half = '0;
      apply_settings(c);
      send_tick(243);
      send_tick(1);
      send_tick(999);
      send_tick(127);
      settle();

      // The receiver holds off while a press is offered on every tick.
      c = RESET_SETTINGS;
      c.poll_interval = '0;
      c.hold_time = 16'd5;
      apply_settings(c);
      sender_calm = 1'b1;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (i = 0; i < 40; i++) begin
         send_tick((i % 2 == 0) ? int'(RST_CHANNEL_LEVEL) : int'(RST_COLOR_LEVEL));
      end
      sender_calm = 1'b0;
      settle();

      phases = 0;
      while (ticks_sent < 480 && phases < 40) begin
         apply_settings(random_settings());
         sender_calm = ($urandom_range(4) == 0);
         rsp_calm <= sender_calm;
         random_phase();
         settle();
         phases++;
      end

      // Long mode press, so the mode key turns into mode hold.
      c = RESET_SETTINGS;
      c.poll_interval = 16'd4;
      c.hold_time = 16'd30;
      apply_settings(c);
      sender_calm = 1'b1;
      rsp_calm <= 1'b0;
      for (i = 0; i < 60; i++) send_tick(int'(RST_MODE_LEVEL));
      settle();

      if (sb.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[sim.f]
design/akpd_pkg.sv
design/akpd_csr.sv
design/akpd_classify.sv
design/analog_keypad_press_decoder_core.sv
design/akpd_checker.sv
tb/sv/tb.sv
